// File: sv/fdc_pkg.sv
// Package for the floppy controller register file: types, constants, CRC helper.
`default_nettype none
package fdc_pkg;
    localparam int MAX_SECTOR_BYTES_DEF = 512;
    localparam int BYTE_GAP_TICKS_DEF   = 32;
    localparam int SEEK_TICKS_DEF       = 500;
    localparam int START_TICKS_DEF      = 2000;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_FILL  = 2'd3;

    localparam logic [1:0] RA_CMD  = 2'd0;
    localparam logic [1:0] RA_TRK  = 2'd1;
    localparam logic [1:0] RA_SEC  = 2'd2;
    localparam logic [1:0] RA_DATA = 2'd3;

    localparam logic [1:0] CFG_SIZE = 2'd0;
    localparam logic [1:0] CFG_WP   = 2'd1;
    localparam logic [1:0] CFG_SIDE = 2'd2;

    localparam logic [1:0] MREQ_NONE   = 2'd0;
    localparam logic [1:0] MREQ_FETCH  = 2'd1;
    localparam logic [1:0] MREQ_COMMIT = 2'd2;

    localparam logic [7:0] ST_BUSY  = 8'h01;
    localparam logic [7:0] ST_DRQ   = 8'h02;
    localparam logic [7:0] ST_T0    = 8'h04;
    localparam logic [7:0] ST_CRC   = 8'h08;
    localparam logic [7:0] ST_RNF   = 8'h10;
    localparam logic [7:0] ST_SPIN  = 8'h20;
    localparam logic [7:0] ST_WP    = 8'h40;
    localparam logic [7:0] ST_MOTOR = 8'h80;

    localparam logic [11:0] ID_GAP_TICKS = 12'd64;

    typedef enum logic [2:0] {
        CL_NONE = 3'd0, CL_I = 3'd1, CL_II = 3'd2, CL_III = 3'd3, CL_IV = 3'd4
    } cmd_class_t;

    typedef enum logic [1:0] {
        TM_IDLE = 2'd0, TM_READ = 2'd1, TM_WRITE = 2'd2, TM_ADDR = 2'd3
    } xfer_mode_t;

    // Controller sequencing: take a transaction, wait for buffer read data, deliver.
    typedef enum logic [1:0] {
        FS_IDLE = 2'd0, FS_EXEC = 2'd1, FS_OUT = 2'd2
    } fsm_state_t;

    typedef struct packed {
        logic load;   // capture the input transaction and issue buffer read
        logic exec;   // apply the transaction to state, build the result
    } dp_cmd_t;

    typedef struct packed {
        logic unused_flag;
    } dp_stat_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

    function automatic cmd_class_t classify(input logic [7:0] cmd);
        cmd_class_t c;
        if (cmd[7:4] < 4'h8) c = CL_I;
        else if (cmd[7:4] < 4'hC) c = CL_II;
        else if (cmd[7:4] == 4'hD) c = CL_IV;
        else c = CL_III;
        return c;
    endfunction
endpackage
`default_nettype wire

// File: sv/fdc_ctrl.sv
// Controller state machine sequencing one transaction at a time.
`default_nettype none
module fdc_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output fdc_pkg::dp_cmd_t     cmd
);
    fdc_pkg::fsm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= fdc_pkg::FS_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fdc_pkg::FS_IDLE: if (s_valid) state_next = fdc_pkg::FS_EXEC;
            fdc_pkg::FS_EXEC: state_next = fdc_pkg::FS_OUT;
            fdc_pkg::FS_OUT:  if (m_ready) state_next = s_valid ? fdc_pkg::FS_EXEC
                                                                : fdc_pkg::FS_IDLE;
            default: state_next = fdc_pkg::FS_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        case (state_reg)
            fdc_pkg::FS_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            fdc_pkg::FS_EXEC: cmd.exec = 1'b1;
            fdc_pkg::FS_OUT: begin
                m_valid  = 1'b1;
                s_ready  = m_ready;
                cmd.load = m_ready && s_valid;
            end
            default: ;
        endcase
    end

    // Each execute is followed by an offered result; nothing is accepted during execute.
    assert property (@(posedge aclk) disable iff (!aresetn) cmd.exec |=> m_valid)
        else $error("result missing after execute");
    assert property (@(posedge aclk) disable iff (!aresetn) cmd.exec |-> !s_ready)
        else $error("accepted during execute");
    assert property (@(posedge aclk) disable iff (!aresetn) (s_valid && s_ready) |=> cmd.exec)
        else $error("accepted transaction not executed");
endmodule
`default_nettype wire

// File: sv/fdc_datapath.sv
// Register file, countdown, sector buffer and ID/CRC logic of the controller.
`default_nettype none
module fdc_datapath #(
    parameter int MAX_SECTOR_BYTES = fdc_pkg::MAX_SECTOR_BYTES_DEF,
    parameter int BYTE_GAP_TICKS   = fdc_pkg::BYTE_GAP_TICKS_DEF,
    parameter int SEEK_TICKS       = fdc_pkg::SEEK_TICKS_DEF,
    parameter int START_TICKS      = fdc_pkg::START_TICKS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire fdc_pkg::dp_cmd_t cmd,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [9:0]       cfg_data,
    input  wire logic [1:0]       s_req_type,
    input  wire logic [1:0]       s_reg_addr,
    input  wire logic [7:0]       s_write_data,
    input  wire logic             s_media_ok,
    input  wire logic [8:0]       s_fill_index,
    output logic [7:0]            m_read_data,
    output logic [7:0]            m_status_byte,
    output logic                  m_drq_line,
    output logic                  m_intrq_line,
    output logic [1:0]            m_media_request,
    output logic [7:0]            m_media_track,
    output logic [7:0]            m_media_sector
);
    localparam int AW = $clog2(MAX_SECTOR_BYTES);
    localparam int SW = $clog2(MAX_SECTOR_BYTES + 1) > 10 ? $clog2(MAX_SECTOR_BYTES + 1) : 10;

    logic [9:0] size_cfg_reg;
    logic       wp_cfg_reg, side_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_cfg_reg <= 10'd256;
            wp_cfg_reg   <= 1'b0;
            side_cfg_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                fdc_pkg::CFG_SIZE: size_cfg_reg <= cfg_data;
                fdc_pkg::CFG_WP:   wp_cfg_reg   <= cfg_data[0];
                fdc_pkg::CFG_SIDE: side_cfg_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [SW-1:0] eff_size;
    always_comb begin
        if (SW'(size_cfg_reg) > SW'(MAX_SECTOR_BYTES)) eff_size = SW'(MAX_SECTOR_BYTES);
        else eff_size = SW'(size_cfg_reg);
    end

    // Latched transaction
    logic [1:0] rt_reg, ra_reg;
    logic [7:0] wd_reg;
    logic       mok_reg;
    logic [8:0] fi_reg;

    // State
    logic [7:0]  status_reg, command_reg, track_reg, sector_reg, data_reg;
    fdc_pkg::cmd_class_t class_reg;
    fdc_pkg::xfer_mode_t mode_reg;
    logic        bdelay_reg, drq_reg, intrq_reg;
    logic [11:0] count_reg;
    logic [SW-1:0] bpos_reg;
    logic [2:0]  idpos_reg;
    logic [3:0]  nid_reg;
    logic [7:0]  idbuf_reg [6];

    logic [7:0] mem [MAX_SECTOR_BYTES];
    logic [7:0] mem_q_reg;

    // Buffer read at the current byte position is the only read address used.
    logic [AW-1:0] rd_addr;
    assign rd_addr = AW'(bpos_reg);

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;

    always_ff @(posedge aclk) begin
        if (cmd.load) mem_q_reg <= mem[rd_addr];
        if (mem_we) mem[mem_wa] <= mem_wd;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rt_reg  <= s_req_type;
            ra_reg  <= s_reg_addr;
            wd_reg  <= s_write_data;
            mok_reg <= s_media_ok;
            fi_reg  <= s_fill_index;
        end
    end

    // CRC over the fixed prefix and the four ID bytes, unrolled per byte at elaboration.
    logic [15:0] crc_a, crc_b;
    always_comb begin
        crc_a = fdc_pkg::crc_byte(16'hFFFF, 8'hA1);
        crc_a = fdc_pkg::crc_byte(crc_a, 8'hA1);
        crc_a = fdc_pkg::crc_byte(crc_a, 8'hA1);
        crc_a = fdc_pkg::crc_byte(crc_a, 8'hFE);
        crc_b = fdc_pkg::crc_byte(crc_a, track_reg);
        crc_b = fdc_pkg::crc_byte(crc_b, {7'd0, side_cfg_reg});
        crc_b = fdc_pkg::crc_byte(crc_b, {4'd0, nid_reg});
        crc_b = fdc_pkg::crc_byte(crc_b, 8'h02);
    end

    // Next-state values
    logic [7:0]  st_n, cmd_n, trk_n, sec_n, dat_n, rd_n;
    fdc_pkg::cmd_class_t cl_n;
    fdc_pkg::xfer_mode_t md_n;
    logic        bd_n, drq_n, irq_n;
    logic [11:0] cnt_n;
    logic [SW-1:0] bp_n;
    logic [2:0]  idp_n;
    logic [3:0]  nid_n;
    logic [7:0]  idb_n [6];
    logic [1:0]  mreq_n;
    fdc_pkg::cmd_class_t cls;
    logic        wok;

    always_comb begin
        st_n = status_reg; cmd_n = command_reg; trk_n = track_reg; sec_n = sector_reg;
        dat_n = data_reg; cl_n = class_reg; md_n = mode_reg; bd_n = bdelay_reg;
        drq_n = drq_reg; irq_n = intrq_reg; cnt_n = count_reg; bp_n = bpos_reg;
        idp_n = idpos_reg; nid_n = nid_reg; idb_n = idbuf_reg;
        rd_n = 8'd0; mreq_n = fdc_pkg::MREQ_NONE;
        mem_we = 1'b0; mem_wa = AW'(fi_reg); mem_wd = wd_reg;
        cls = fdc_pkg::classify(wd_reg);
        wok = 1'b0;
        case (rt_reg)
            fdc_pkg::REQ_READ: begin
                case (ra_reg)
                    fdc_pkg::RA_CMD: begin rd_n = status_reg; irq_n = 1'b0; end
                    fdc_pkg::RA_TRK: rd_n = track_reg;
                    fdc_pkg::RA_SEC: rd_n = sector_reg;
                    default: begin
                        rd_n = data_reg;
                        if (class_reg == fdc_pkg::CL_III && mode_reg == fdc_pkg::TM_ADDR
                            && drq_reg) begin
                            rd_n = 8'hFF;
                            if (idpos_reg < 3'd6) begin
                                rd_n  = idbuf_reg[idpos_reg];
                                idp_n = idpos_reg + 3'd1;
                            end
                            if (idpos_reg == 3'd2) sec_n = rd_n;
                            dat_n = rd_n;
                            drq_n = 1'b0;
                            if (idp_n >= 3'd6) begin
                                md_n = fdc_pkg::TM_IDLE; bd_n = 1'b0; bp_n = '0; idp_n = '0;
                                cnt_n = '0; drq_n = 1'b0; irq_n = 1'b1;
                                cl_n = fdc_pkg::CL_NONE;
                                st_n = st_n & ~(fdc_pkg::ST_DRQ | fdc_pkg::ST_BUSY);
                            end else begin
                                st_n = st_n & ~fdc_pkg::ST_DRQ;
                                bd_n = 1'b1; cnt_n = fdc_pkg::ID_GAP_TICKS;
                            end
                        end else if (class_reg == fdc_pkg::CL_II
                                     && command_reg[7:5] == 3'b100
                                     && mode_reg == fdc_pkg::TM_READ && drq_reg) begin
                            if (bpos_reg < eff_size) begin
                                rd_n = mem_q_reg; bp_n = bpos_reg + SW'(1);
                            end
                            dat_n = rd_n;
                            if (bp_n >= eff_size) begin
                                md_n = fdc_pkg::TM_IDLE; bd_n = 1'b0; bp_n = '0; idp_n = '0;
                                cnt_n = '0; drq_n = 1'b0; irq_n = 1'b1;
                                cl_n = fdc_pkg::CL_NONE;
                                st_n = st_n & ~(fdc_pkg::ST_DRQ | fdc_pkg::ST_BUSY);
                            end else begin
                                drq_n = 1'b0; st_n = st_n & ~fdc_pkg::ST_DRQ;
                                cnt_n = 12'(BYTE_GAP_TICKS);
                            end
                        end
                    end
                endcase
            end
            fdc_pkg::REQ_WRITE: begin
                case (ra_reg)
                    fdc_pkg::RA_CMD: begin
                        if (!(status_reg[0] && cls != fdc_pkg::CL_IV)) begin
                            cmd_n = wd_reg; cl_n = cls;
                            md_n = fdc_pkg::TM_IDLE; drq_n = 1'b0; irq_n = 1'b0;
                            st_n = st_n & ~fdc_pkg::ST_DRQ;
                            if (cls == fdc_pkg::CL_I)
                                st_n = st_n & ~(fdc_pkg::ST_CRC | fdc_pkg::ST_RNF |
                                    fdc_pkg::ST_SPIN | fdc_pkg::ST_WP | fdc_pkg::ST_MOTOR);
                            else
                                st_n = st_n & ~(fdc_pkg::ST_T0 | fdc_pkg::ST_CRC |
                                    fdc_pkg::ST_RNF | fdc_pkg::ST_SPIN | fdc_pkg::ST_WP |
                                    fdc_pkg::ST_MOTOR);
                            st_n = st_n | fdc_pkg::ST_BUSY;
                            cnt_n = '0;
                            case (cls)
                                fdc_pkg::CL_I: begin
                                    case (wd_reg[7:4])
                                        4'h0: begin trk_n = 8'd0; nid_n = 4'd1; end
                                        4'h1: begin trk_n = data_reg; nid_n = 4'd1; end
                                        4'h2: nid_n = 4'd1;
                                        4'h4: begin trk_n = track_reg + 8'd1; nid_n = 4'd1; end
                                        4'h6: begin
                                            if (track_reg != 8'd0) trk_n = track_reg - 8'd1;
                                            nid_n = 4'd1;
                                        end
                                        default: ;
                                    endcase
                                    st_n = (trk_n == 8'd0) ? (st_n | fdc_pkg::ST_T0)
                                                           : (st_n & ~fdc_pkg::ST_T0);
                                    cnt_n = 12'(SEEK_TICKS);
                                end
                                fdc_pkg::CL_II: begin
                                    if (wd_reg[7:5] == 3'b100) begin
                                        mreq_n = fdc_pkg::MREQ_FETCH;
                                        if (mok_reg) begin
                                            bp_n = '0; md_n = fdc_pkg::TM_READ;
                                            cnt_n = 12'(START_TICKS);
                                        end else begin
                                            st_n = (st_n | fdc_pkg::ST_RNF) & ~fdc_pkg::ST_BUSY;
                                            irq_n = 1'b1; cnt_n = 12'd1;
                                        end
                                    end else begin
                                        bp_n = '0; md_n = fdc_pkg::TM_WRITE;
                                        cnt_n = 12'(START_TICKS);
                                    end
                                end
                                fdc_pkg::CL_III: begin
                                    if (wd_reg[7:4] == 4'hC) begin
                                        idp_n = '0; md_n = fdc_pkg::TM_ADDR;
                                        idb_n[0] = track_reg;
                                        idb_n[1] = {7'd0, side_cfg_reg};
                                        idb_n[2] = {4'd0, nid_reg};
                                        idb_n[3] = 8'h02;
                                        idb_n[4] = crc_b[15:8];
                                        idb_n[5] = crc_b[7:0];
                                        nid_n = (nid_reg + 4'd1 > 4'd10) ? 4'd1 : nid_reg + 4'd1;
                                    end
                                    cnt_n = 12'(START_TICKS);
                                end
                                default: begin
                                    st_n = st_n & ~fdc_pkg::ST_BUSY;
                                    bd_n = 1'b0;
                                    irq_n = (wd_reg[3:0] != 4'd0);
                                end
                            endcase
                        end
                    end
                    fdc_pkg::RA_TRK: trk_n = wd_reg;
                    fdc_pkg::RA_SEC: sec_n = wd_reg;
                    default: begin
                        dat_n = wd_reg;
                        if (class_reg == fdc_pkg::CL_II && command_reg[7:5] == 3'b101
                            && mode_reg == fdc_pkg::TM_WRITE && drq_reg) begin
                            if (bpos_reg < eff_size) begin
                                mem_we = 1'b1; mem_wa = AW'(bpos_reg);
                                bp_n = bpos_reg + SW'(1);
                                drq_n = 1'b0; st_n = st_n & ~fdc_pkg::ST_DRQ;
                            end
                            if (bp_n >= eff_size) begin
                                if (wp_cfg_reg) begin
                                    st_n = st_n | fdc_pkg::ST_WP;
                                end else begin
                                    mreq_n = fdc_pkg::MREQ_COMMIT;
                                    wok = mok_reg;
                                    if (!wok) st_n = st_n | fdc_pkg::ST_RNF;
                                end
                                md_n = fdc_pkg::TM_IDLE; bd_n = 1'b0; bp_n = '0; idp_n = '0;
                                cnt_n = '0; drq_n = 1'b0; irq_n = 1'b1;
                                cl_n = fdc_pkg::CL_NONE;
                                st_n = st_n & ~(fdc_pkg::ST_DRQ | fdc_pkg::ST_BUSY);
                            end else begin
                                cnt_n = 12'(BYTE_GAP_TICKS);
                            end
                        end
                    end
                endcase
            end
            fdc_pkg::REQ_TICK: begin
                if (count_reg != 12'd0) begin
                    cnt_n = count_reg - 12'd1;
                    if (cnt_n == 12'd0) begin
                        if (class_reg == fdc_pkg::CL_II && mode_reg == fdc_pkg::TM_READ
                            && bpos_reg < eff_size) begin
                            dat_n = mem_q_reg; drq_n = 1'b1; st_n = st_n | fdc_pkg::ST_DRQ;
                        end else if (class_reg == fdc_pkg::CL_II
                                     && mode_reg == fdc_pkg::TM_WRITE
                                     && bpos_reg < eff_size) begin
                            drq_n = 1'b1; st_n = st_n | fdc_pkg::ST_DRQ;
                        end else if (class_reg == fdc_pkg::CL_III
                                     && mode_reg == fdc_pkg::TM_ADDR
                                     && idpos_reg < 3'd6) begin
                            bd_n = 1'b0; dat_n = idbuf_reg[idpos_reg]; drq_n = 1'b1;
                            st_n = st_n | fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ;
                        end else if (class_reg == fdc_pkg::CL_I || class_reg == fdc_pkg::CL_II
                                     || class_reg == fdc_pkg::CL_III) begin
                            if (class_reg == fdc_pkg::CL_I) begin
                                st_n = (track_reg == 8'd0) ? (st_n | fdc_pkg::ST_T0)
                                                           : (st_n & ~fdc_pkg::ST_T0);
                                st_n = st_n & ~fdc_pkg::ST_MOTOR;
                            end
                            md_n = fdc_pkg::TM_IDLE; bd_n = 1'b0; bp_n = '0; idp_n = '0;
                            cnt_n = '0; drq_n = 1'b0; irq_n = 1'b1;
                            cl_n = fdc_pkg::CL_NONE;
                            st_n = st_n & ~(fdc_pkg::ST_DRQ | fdc_pkg::ST_BUSY);
                        end
                    end
                end
            end
            default: begin
                if ({23'd0, fi_reg} < MAX_SECTOR_BYTES) mem_we = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= '0; command_reg <= '0; track_reg <= '0; sector_reg <= '0;
            data_reg <= '0; class_reg <= fdc_pkg::CL_NONE; mode_reg <= fdc_pkg::TM_IDLE;
            bdelay_reg <= 1'b0; drq_reg <= 1'b0; intrq_reg <= 1'b0; count_reg <= '0;
            bpos_reg <= '0; idpos_reg <= '0; nid_reg <= 4'd1;
            for (int i = 0; i < 6; i++) idbuf_reg[i] <= '0;
        end else if (cmd.exec) begin
            status_reg <= st_n; command_reg <= cmd_n; track_reg <= trk_n; sector_reg <= sec_n;
            data_reg <= dat_n; class_reg <= cl_n; mode_reg <= md_n; bdelay_reg <= bd_n;
            drq_reg <= drq_n; intrq_reg <= irq_n; count_reg <= cnt_n; bpos_reg <= bp_n;
            idpos_reg <= idp_n; nid_reg <= nid_n; idbuf_reg <= idb_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_read_data     <= rd_n;
            m_status_byte   <= st_n;
            m_drq_line      <= drq_n;
            m_intrq_line    <= irq_n;
            m_media_request <= mreq_n;
            m_media_track   <= (mreq_n != fdc_pkg::MREQ_NONE) ? trk_n : 8'd0;
            m_media_sector  <= (mreq_n != fdc_pkg::MREQ_NONE) ? sec_n : 8'd0;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) drq_reg == status_reg[1])
        else $error("drq flag and status bit disagree");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (nid_reg >= 4'd1) && (nid_reg <= 4'd10))
        else $error("rotating sector id out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (class_reg == fdc_pkg::CL_NONE) |-> (mode_reg == fdc_pkg::TM_IDLE))
        else $error("transfer active without command");
endmodule
`default_nettype wire

// File: sv/floppy_disk_controller_registers.sv
// Top level of the floppy controller register file.
// A transaction is accepted, executed in the next cycle, and its result
// is offered the cycle after; the sector-buffer read is registered at
// acceptance, and a new transaction is taken only while idle or while m_ready takes the result.
// Reset (aresetn low, synchronous) resets controller state and configuration,
// but not the outputs; the sector buffer holds no reset and needs no clearing pass.
`default_nettype none
module floppy_disk_controller_registers #(
    parameter int MAX_SECTOR_BYTES = fdc_pkg::MAX_SECTOR_BYTES_DEF,
    parameter int BYTE_GAP_TICKS   = fdc_pkg::BYTE_GAP_TICKS_DEF,
    parameter int SEEK_TICKS       = fdc_pkg::SEEK_TICKS_DEF,
    parameter int START_TICKS      = fdc_pkg::START_TICKS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [9:0] cfg_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_req_type,
    input  wire logic [1:0] s_reg_addr,
    input  wire logic [7:0] s_write_data,
    input  wire logic       s_media_ok,
    input  wire logic [8:0] s_fill_index,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_read_data,
    output logic [7:0]      m_status_byte,
    output logic            m_drq_line,
    output logic            m_intrq_line,
    output logic [1:0]      m_media_request,
    output logic [7:0]      m_media_track,
    output logic [7:0]      m_media_sector
);
    fdc_pkg::dp_cmd_t cmd;

    // Sequence each transaction: load, execute, deliver.
    fdc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd)
    );

    // Hold all controller state and the sector buffer.
    fdc_datapath #(
        .MAX_SECTOR_BYTES(MAX_SECTOR_BYTES), .BYTE_GAP_TICKS(BYTE_GAP_TICKS),
        .SEEK_TICKS(SEEK_TICKS), .START_TICKS(START_TICKS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_req_type(s_req_type), .s_reg_addr(s_reg_addr), .s_write_data(s_write_data),
        .s_media_ok(s_media_ok), .s_fill_index(s_fill_index),
        .m_read_data(m_read_data), .m_status_byte(m_status_byte),
        .m_drq_line(m_drq_line), .m_intrq_line(m_intrq_line),
        .m_media_request(m_media_request), .m_media_track(m_media_track),
        .m_media_sector(m_media_sector)
    );
endmodule
`default_nettype wire

// File: verif/tb_floppy_disk_controller_registers.sv
// Testbench for the floppy controller register file: predicted transactions checked in order.
module tb_floppy_disk_controller_registers;
    import fdc_pkg::*;

    // One request transaction and the one result it produces.
    typedef struct packed {
        logic [1:0] req;
        logic [1:0] addr;
        logic [7:0] wdata;
        logic       mok;
        logic [8:0] fidx;
    } fdc_item_t;

    typedef struct packed {
        logic [7:0] rd;
        logic [7:0] st;
        logic       drq;
        logic       intrq;
        logic [1:0] mreq;
        logic [7:0] mtrk;
        logic [7:0] msec;
    } fdc_result_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [9:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_req_type;
    logic [1:0] s_reg_addr;
    logic [7:0] s_write_data;
    logic       s_media_ok;
    logic [8:0] s_fill_index;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_read_data;
    logic [7:0] m_status_byte;
    logic       m_drq_line;
    logic       m_intrq_line;
    logic [1:0] m_media_request;
    logic [7:0] m_media_track;
    logic [7:0] m_media_sector;

    floppy_disk_controller_registers DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_reg_addr(s_reg_addr), .s_write_data(s_write_data),
        .s_media_ok(s_media_ok), .s_fill_index(s_fill_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_data(m_read_data),
        .m_status_byte(m_status_byte), .m_drq_line(m_drq_line),
        .m_intrq_line(m_intrq_line), .m_media_request(m_media_request),
        .m_media_track(m_media_track), .m_media_sector(m_media_sector)
    );

    always begin
        aclk = 1'b1; #10;
        aclk = 1'b0; #10;
    end

    fdc_item_t   pending_reqs[$];
    fdc_result_t expected_results[$];
    int          mismatches = 0;
    int          ops = 0;
    logic        in_took = 1'b0;
    int          in_idle = 0;
    int          out_idle = 0;
    bit          calm = 1'b0;

    // ------------------------------------------------------------------
    // Predicted controller state and configuration
    // ------------------------------------------------------------------
    logic [9:0]  cur_size;
    logic        cur_wp;
    logic        cur_side;
    logic [7:0]  p_status, p_cmd, p_track, p_sector, p_data;
    cmd_class_t  p_class;
    xfer_mode_t  p_mode;
    logic        p_bdelay, p_drq, p_intrq;
    int          p_count, p_pos, p_idpos, p_nextid;
    logic [7:0]  p_idbuf[6];
    logic [7:0]  p_buf[512];

    function automatic int size_eff();
        return (cur_size > 10'd512) ? 512 : int'(cur_size);
    endfunction

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    function automatic cmd_class_t class_of(input logic [7:0] cmd);
        if (cmd[7:4] < 4'h8) return CL_I;
        if (cmd[7:4] < 4'hC) return CL_II;
        if (cmd[7:4] == 4'hD) return CL_IV;
        return CL_III;
    endfunction

    task automatic put_drq(input logic on);
        p_drq = on;
        p_status = on ? (p_status | ST_DRQ) : (p_status & ~ST_DRQ);
    endtask

    task automatic put_busy(input logic on);
        p_status = on ? (p_status | ST_BUSY) : (p_status & ~ST_BUSY);
    endtask

    task automatic mark_track0();
        p_status = (p_track == 8'd0) ? (p_status | ST_T0) : (p_status & ~ST_T0);
        p_status = p_status & ~ST_MOTOR;
    endtask

    task automatic end_command();
        p_mode = TM_IDLE;
        p_bdelay = 1'b0;
        p_pos = 0;
        p_idpos = 0;
        p_count = 0;
        put_drq(1'b0);
        put_busy(1'b0);
        p_intrq = 1'b1;
        p_class = CL_NONE;
    endtask

    task automatic model_reset();
        cur_size = 10'd256; cur_wp = 1'b0; cur_side = 1'b0;
        p_status = 0; p_cmd = 0; p_track = 0; p_sector = 0; p_data = 0;
        p_class = CL_NONE; p_mode = TM_IDLE;
        p_bdelay = 0; p_drq = 0; p_intrq = 0;
        p_count = 0; p_pos = 0; p_idpos = 0; p_nextid = 1;
        for (int i = 0; i < 6; i++) p_idbuf[i] = 8'h00;
    endtask

    task automatic begin_command(input logic [7:0] cmd, input logic mok,
                                 inout logic [1:0] mreq);
        logic [15:0] crc;
        p_mode = TM_IDLE;
        put_drq(1'b0);
        p_intrq = 1'b0;
        if (p_class == CL_I) begin
            p_status = p_status & ~(ST_CRC | ST_RNF | ST_SPIN | ST_WP | ST_MOTOR);
            mark_track0();
        end else begin
            p_status = p_status & ~(ST_T0 | ST_CRC | ST_RNF | ST_SPIN | ST_WP | ST_MOTOR);
        end
        put_busy(1'b1);
        p_count = 0;
        case (p_class)
            CL_I: begin
                // Update-code steps (0x30, 0x50, 0x70) fall to default: track stays.
                case (cmd[7:4])
                    4'h0: begin p_track = 8'd0; p_nextid = 1; end
                    4'h1: begin p_track = p_data; p_nextid = 1; end
                    4'h2: p_nextid = 1;
                    4'h4: begin p_track = p_track + 8'd1; p_nextid = 1; end
                    4'h6: begin
                        if (p_track > 0) p_track = p_track - 8'd1;
                        p_nextid = 1;
                    end
                    default: ;
                endcase
                mark_track0();
                p_count = SEEK_TICKS_DEF;
            end
            CL_II: begin
                if (cmd[7:5] == 3'b100) begin
                    mreq = MREQ_FETCH;
                    if (mok) begin
                        p_pos = 0;
                        p_mode = TM_READ;
                        p_count = START_TICKS_DEF;
                    end else begin
                        // Sector not found: interrupt now, finish one tick later.
                        p_status = p_status | ST_RNF;
                        put_busy(1'b0);
                        put_drq(1'b0);
                        p_intrq = 1'b1;
                        p_count = 1;
                    end
                end else begin
                    p_pos = 0;
                    p_mode = TM_WRITE;
                    p_count = START_TICKS_DEF;
                end
            end
            CL_III: begin
                if (cmd[7:4] == 4'hC) begin
                    p_idpos = 0;
                    p_mode = TM_ADDR;
                    p_idbuf[0] = p_track;
                    p_idbuf[1] = {7'd0, cur_side};
                    p_idbuf[2] = p_nextid[7:0];
                    p_idbuf[3] = 8'h02;
                    p_nextid++;
                    if (p_nextid > 10) p_nextid = 1;
                    crc = 16'hFFFF;
                    crc = crc_step(crc, 8'hA1);
                    crc = crc_step(crc, 8'hA1);
                    crc = crc_step(crc, 8'hA1);
                    crc = crc_step(crc, 8'hFE);
                    for (int i = 0; i < 4; i++) crc = crc_step(crc, p_idbuf[i]);
                    p_idbuf[4] = crc[15:8];
                    p_idbuf[5] = crc[7:0];
                end
                p_count = START_TICKS_DEF;
            end
            default: begin
                put_busy(1'b0);
                put_drq(1'b0);
                p_mode = TM_IDLE;
                p_bdelay = 1'b0;
                p_intrq = (cmd[3:0] != 4'h0);
                p_count = 0;
            end
        endcase
    endtask

    task automatic tick_event();
        if (p_count == 0) return;
        p_count--;
        if (p_count != 0) return;
        case (p_class)
            CL_I: begin mark_track0(); end_command(); end
            CL_II: begin
                if (p_mode == TM_READ && p_pos < size_eff()) begin
                    p_data = p_buf[p_pos];
                    put_drq(1'b1);
                end else if (p_mode == TM_WRITE && p_pos < size_eff()) begin
                    put_drq(1'b1);
                end else begin
                    end_command();
                end
            end
            CL_III: begin
                if (p_mode == TM_ADDR && p_idpos < 6) begin
                    p_bdelay = 1'b0;
                    p_data = p_idbuf[p_idpos];
                    put_busy(1'b1);
                    put_drq(1'b1);
                end else begin
                    end_command();
                end
            end
            default: ;
        endcase
    endtask

    task automatic data_port_read(output logic [7:0] v);
        int idx;
        v = p_data;
        if (p_class == CL_III && p_mode == TM_ADDR) begin
            if (!p_drq) return;
            idx = p_idpos;
            v = 8'hFF;
            if (p_idpos < 6) begin v = p_idbuf[p_idpos]; p_idpos++; end
            if (idx == 2) p_sector = v;
            p_data = v;
            put_drq(1'b0);
            if (p_idpos >= 6) end_command();
            else begin p_bdelay = 1'b1; p_count = ID_GAP_TICKS; end
        end else if (p_class == CL_II && p_cmd[7:5] == 3'b100 && p_mode == TM_READ) begin
            if (!p_drq) return;
            if (p_pos < size_eff()) begin v = p_buf[p_pos]; p_pos++; end
            p_data = v;
            put_drq(1'b0);
            if (p_pos >= size_eff()) end_command();
            else p_count = BYTE_GAP_TICKS_DEF;
        end
    endtask

    task automatic data_port_write(input logic [7:0] val, input logic mok,
                                   inout logic [1:0] mreq);
        logic ok;
        if (p_class == CL_II && p_cmd[7:5] == 3'b101 && p_mode == TM_WRITE) begin
            if (!p_drq) begin p_data = val; return; end
            if (p_pos < size_eff()) begin
                p_buf[p_pos] = val;
                p_pos++;
                p_data = val;
                put_drq(1'b0);
            end
            if (p_pos >= size_eff()) begin
                // Last byte: commit unless protected.
                if (cur_wp) begin
                    p_status = p_status | ST_WP;
                    ok = 1'b0;
                end else begin
                    mreq = MREQ_COMMIT;
                    ok = mok;
                end
                if (!ok && (p_status & ST_WP) == 0) p_status = p_status | ST_RNF;
                end_command();
                return;
            end
            p_count = BYTE_GAP_TICKS_DEF;
            return;
        end
        p_data = val;
    endtask

    task automatic predict_step(input fdc_item_t it, output fdc_result_t r);
        logic [7:0] rd;
        logic [1:0] mreq;
        cmd_class_t c;
        rd = 8'h00;
        mreq = MREQ_NONE;
        case (it.req)
            REQ_READ: begin
                case (it.addr)
                    RA_CMD:  begin rd = p_status; p_intrq = 1'b0; end
                    RA_TRK:  rd = p_track;
                    RA_SEC:  rd = p_sector;
                    default: data_port_read(rd);
                endcase
            end
            REQ_WRITE: begin
                case (it.addr)
                    RA_CMD: begin
                        c = class_of(it.wdata);
                        // A busy controller ignores all but force interrupt.
                        if (!((p_status & ST_BUSY) != 0 && c != CL_IV)) begin
                            p_cmd = it.wdata;
                            p_class = c;
                            begin_command(it.wdata, it.mok, mreq);
                        end
                    end
                    RA_TRK:  p_track = it.wdata;
                    RA_SEC:  p_sector = it.wdata;
                    default: data_port_write(it.wdata, it.mok, mreq);
                endcase
            end
            REQ_TICK: tick_event();
            default:  p_buf[it.fidx] = it.wdata;
        endcase
        r.rd    = rd;
        r.st    = p_status;
        r.drq   = p_drq;
        r.intrq = p_intrq;
        r.mreq  = mreq;
        r.mtrk  = (mreq != MREQ_NONE) ? p_track : 8'h00;
        r.msec  = (mreq != MREQ_NONE) ? p_sector : 8'h00;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Predict a transaction, then queue it for the driver.
    task automatic issue(input logic [1:0] req, input logic [1:0] addr,
                         input logic [7:0] wd, input logic mok, input logic [8:0] fi);
        fdc_item_t   it;
        fdc_result_t r;
        it = '{req: req, addr: addr, wdata: wd, mok: mok, fidx: fi};
        predict_step(it, r);
        expected_results.push_back(r);
        pending_reqs.push_back(it);
        if (req != REQ_TICK) ops++;
    endtask

    task automatic issue_cmd(input logic [7:0] cmd, input logic mok);
        issue(REQ_WRITE, RA_CMD, cmd, mok, 9'($urandom));
    endtask

    task automatic issue_tick();
        issue(REQ_TICK, 2'($urandom), 8'($urandom), 1'($urandom), 9'($urandom));
    endtask

    // Tick the controller and serve data requests until it goes idle or the cap runs out.
    task automatic run_command(input int cap);
        int n;
        for (n = 0; n < cap; n++) begin
            if ((p_status & ST_BUSY) == 0 && !p_drq) break;
            if (p_drq) begin
                if (p_mode == TM_WRITE)
                    issue(REQ_WRITE, RA_DATA, 8'($urandom), $urandom_range(0, 5) != 0,
                          9'($urandom));
                else
                    issue(REQ_READ, RA_DATA, 8'($urandom), 1'($urandom), 9'($urandom));
            end else if ($urandom_range(0, 29) == 0) begin
                case ($urandom_range(0, 4))
                    0: issue(REQ_READ, RA_CMD, 8'($urandom), 1'($urandom), 9'($urandom));
                    1: issue(REQ_READ, RA_TRK, 8'($urandom), 1'($urandom), 9'($urandom));
                    2: issue(REQ_READ, RA_DATA, 8'($urandom), 1'($urandom), 9'($urandom));
                    3: issue(REQ_WRITE, RA_SEC, 8'($urandom), 1'($urandom), 9'($urandom));
                    default: issue(REQ_FILL, 2'($urandom), 8'($urandom), 1'($urandom),
                                   9'($urandom));
                endcase
            end else begin
                issue_tick();
            end
        end
    endtask

    task automatic random_sequence();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: begin
                if ($urandom_range(0, 1)) issue(REQ_WRITE, RA_DATA, 8'($urandom), 0, 0);
                if ($urandom_range(0, 2) == 0)
                    issue(REQ_WRITE, RA_TRK, 8'($urandom_range(0, 2) == 0 ? 0 : $urandom),
                          0, 0);
                issue_cmd(8'($urandom_range(0, 127)), 1'($urandom));
            end
            2, 3: begin
                issue(REQ_WRITE, RA_TRK, 8'($urandom), 0, 0);
                issue(REQ_WRITE, RA_SEC, 8'($urandom), 0, 0);
                repeat ($urandom_range(0, 3))
                    issue(REQ_FILL, 2'($urandom), 8'($urandom), 1'($urandom),
                          9'($urandom_range(0, 7)));
                issue_cmd(8'h80 | 8'($urandom_range(0, 31)), $urandom_range(0, 5) != 0);
            end
            4, 5: begin
                issue(REQ_WRITE, RA_SEC, 8'($urandom), 0, 0);
                issue_cmd(8'hA0 | 8'($urandom_range(0, 31)), 1'($urandom));
            end
            6: issue_cmd(8'hC0 | 8'($urandom_range(0, 15)), 1'($urandom));
            7: issue_cmd(8'hE0 | 8'($urandom_range(0, 31)), 1'($urandom));
            8: begin
                // Abort a command part way, after trying to start another while busy.
                issue_cmd(8'($urandom_range(0, 255)), 1'($urandom));
                run_command($urandom_range(0, 2500));
                issue_cmd(8'($urandom_range(0, 127)), 1'($urandom));
                issue_cmd(8'hD0 | 8'($urandom_range(0, 15)), 1'($urandom));
            end
            default: begin
                repeat ($urandom_range(4, 12))
                    issue(2'($urandom), 2'($urandom), 8'($urandom), 1'($urandom),
                          9'($urandom));
            end
        endcase
        run_command(40000);
        if ($urandom_range(0, 1)) issue(REQ_READ, RA_CMD, 0, 0, 0);
    endtask

    // Hold until every transaction has been accepted and answered.
    task automatic drain();
        while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [9:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SIZE: cur_size = val;
            CFG_WP:   cur_wp = val[0];
            default:  cur_side = val[0];
        endcase
    endtask

    task automatic set_config(input logic [9:0] size, input logic wp, input logic side);
        cfg_write(CFG_SIZE, size);
        cfg_write(CFG_WP, {9'd0, wp});
        cfg_write(CFG_SIDE, {9'd0, side});
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued transactions with random gaps, change on falling edge
    // ------------------------------------------------------------------
    always @(posedge aclk) in_took <= s_valid && s_ready;

    always @(negedge aclk) begin
        fdc_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
            in_idle = 0;
        end else if (!(s_valid && !in_took)) begin
            if (s_valid) in_idle = gap_len();
            if (in_idle > 0) begin
                in_idle--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                it = pending_reqs.pop_front();
                s_valid      <= 1'b1;
                s_req_type   <= it.req;
                s_reg_addr   <= it.addr;
                s_write_data <= it.wdata;
                s_media_ok   <= it.mok;
                s_fill_index <= it.fidx;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure; flip into calm stretches now and then.
    always @(negedge aclk) begin
        if ($urandom_range(0, 399) == 0) calm = !calm;
        if (out_idle == 0 && $urandom_range(0, 2) == 0) out_idle = gap_len();
        if (out_idle > 0) begin
            out_idle--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transaction with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        fdc_result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{rd: m_read_data, st: m_status_byte, drq: m_drq_line,
                    intrq: m_intrq_line, mreq: m_media_request,
                    mtrk: m_media_track, msec: m_media_sector};
            if (expected_results.size() == 0) begin
                if (mismatches < 10) $display("unexpected result transaction: %p", got);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    if (mismatches < 10)
                        $display("mismatch: expected %p, actual %p", want, got);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0; cfg_index = 2'd0; cfg_data = 10'd0;
        s_valid = 1'b0; s_req_type = 2'd0; s_reg_addr = 2'd0;
        s_write_data = 8'd0; s_media_ok = 1'b0; s_fill_index = 9'd0;
        m_ready = 1'b0;
        model_reset();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Fill the whole sector buffer first so no read ever sees an unwritten entry.
        for (int i = 0; i < 512; i++)
            issue(REQ_FILL, 2'($urandom), 8'($urandom), 1'($urandom), 9'(i));
        drain();
        set_config(10'd2, 1'b0, 1'b0);

        // Directed: register extremes, each command family, the special cases.
        issue(REQ_READ, RA_CMD, 0, 0, 0);
        issue(REQ_READ, RA_TRK, 0, 0, 0);
        issue(REQ_READ, RA_SEC, 0, 0, 0);
        issue(REQ_READ, RA_DATA, 0, 0, 0);
        issue(REQ_WRITE, RA_TRK, 8'hFF, 0, 0);
        issue(REQ_WRITE, RA_SEC, 8'h00, 0, 0);
        issue(REQ_WRITE, RA_DATA, 8'h80, 0, 0);
        issue_cmd(8'h4F, 1'b0);                   // step in from 255 wraps to 0
        issue_cmd(8'h00, 1'b0);                   // ignored while busy
        run_command(40000);
        issue_cmd(8'h1F, 1'b0); run_command(40000);  // seek to data register
        issue_cmd(8'h6F, 1'b0); run_command(40000);  // step out
        issue_cmd(8'h30, 1'b0); run_command(40000);  // update codes keep the track
        issue_cmd(8'h50, 1'b0); run_command(40000);
        issue_cmd(8'h70, 1'b0); run_command(40000);
        issue_cmd(8'h20, 1'b0); run_command(40000);
        issue_cmd(8'h00, 1'b0); run_command(40000);  // restore
        issue_cmd(8'h80, 1'b1); run_command(40000);  // read sector, found
        issue_cmd(8'h9F, 1'b0);                   // read sector, not found
        issue_tick();
        issue(REQ_READ, RA_DATA, 0, 0, 0);         // data read without DRQ
        issue_cmd(8'hA0, 1'b1);
        issue(REQ_WRITE, RA_DATA, 8'h5A, 1'b1, 0); // data write without DRQ
        run_command(40000);
        issue_cmd(8'hBF, 1'b0); run_command(40000);  // write sector, commit accepted or rejected at random
        issue_cmd(8'hC0, 1'b0); run_command(40000);  // read address
        issue_cmd(8'hE0, 1'b0); run_command(40000);  // read track
        issue_cmd(8'hF0, 1'b0); run_command(300);
        issue_cmd(8'hD8, 1'b0);                   // force interrupt mid command
        issue(REQ_READ, RA_CMD, 0, 0, 0);
        issue_cmd(8'hD0, 1'b0);
        drain();

        // Largest size saturates; protected commit; side one in the ID field.
        set_config(10'h3FF, 1'b1, 1'b1);
        issue_cmd(8'h80, 1'b1); run_command(40000);
        issue_cmd(8'hA0, 1'b1); run_command(40000);
        issue_cmd(8'hC0, 1'b1); run_command(40000);
        drain();

        // Zero size ends each transfer at its first event.
        set_config(10'd0, 1'b0, 1'b1);
        issue_cmd(8'h80, 1'b1); run_command(40000);
        issue_cmd(8'hA0, 1'b1); run_command(40000);
        drain();

        // Random phases with small sectors and shuffled flags.
        for (int ph = 0; ph < 6; ph++) begin
            int target;
            set_config(10'($urandom_range(1, 6)), 1'($urandom), 1'($urandom));
            target = ops + 125;
            while (ops < target) random_sequence();
            drain();
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("** floppy_disk_controller_registers: PASSED **");
        end else begin
            $display("** floppy_disk_controller_registers: FAILED **");
        end
        $finish;
    end

    // Drop the run if it hangs.
    initial begin
        repeat (20) #250000000;
        $display("** floppy_disk_controller_registers: FAILED **");
        $finish;
    end
endmodule
